// ===== sv/crfe_pkg.sv =====
// ============================================================================
// crfe_pkg
// Shared types and constants of the clipped rectangle fill engine.
// ============================================================================
`default_nettype none

package crfe_pkg;

    localparam int LINE_STRIDE_DEF = 1024;
    localparam int FRAME_ROWS_DEF  = 768;

    localparam int FUNC_W     = 2;
    localparam int COORD_W    = 12;
    localparam int COLOR_W    = 8;
    localparam int COUNT_W    = 20;
    localparam int EDGE_W     = 10;
    localparam int SCREEN_W   = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CLIP_W     = 15;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 32;

    localparam logic [FUNC_W-1:0] FUNC_OVERWRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OR        = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MIX       = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_COLOR     = 3'd6;

    localparam logic [EDGE_W-1:0]   CLIP_LEFT_RST     = 10'd0;
    localparam logic [EDGE_W-1:0]   CLIP_TOP_RST      = 10'd0;
    localparam logic [EDGE_W-1:0]   CLIP_RIGHT_RST    = 10'd1023;
    localparam logic [EDGE_W-1:0]   CLIP_BOTTOM_RST   = 10'd767;
    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 11'd1024;
    localparam logic [COLOR_W-1:0]  MIX_THRESHOLD_RST = 8'd15;
    localparam logic [COLOR_W-1:0]  MIX_COLOR_RST     = 8'd255;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic clip;
        logic size;
        logic count;
        logic walk;
        logic read_issue;
        logic result_load;
    } crfe_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic empty;
        logic walk_last;
    } crfe_sts_t;

endpackage

`default_nettype wire

// ===== sv/crfe_ram.sv =====
// ============================================================================
// crfe_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
`default_nettype none

module crfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/crfe_ctrl.sv =====
// ============================================================================
// crfe_ctrl
// Command sequencer: clearing pass, clipping, pixel walk and result hand-off.
// ============================================================================
`default_nettype none

module crfe_ctrl
    import crfe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output crfe_cmd_t      cmd,
    input  wire crfe_sts_t sts
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_CLIP  = 8'b0000_0100,
        ST_SIZE  = 8'b0000_1000,
        ST_READ  = 8'b0001_0000,
        ST_COUNT = 8'b0010_0000,
        ST_RUN   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = ST_SIZE;
            end
            ST_SIZE:
            begin
                cmd.size   = 1'b1;
                state_next = sts.is_read ? ST_READ : ST_COUNT;
            end
            ST_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = ST_DONE;
            end
            ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = sts.empty ? ST_DONE : ST_RUN;
            end
            ST_RUN:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/crfe_dp.sv =====
// ============================================================================
// crfe_dp
// Datapath: configuration registers, clipping, address walk, pixel update
// and the frame store.
// ============================================================================
`default_nettype none

module crfe_dp
    import crfe_pkg::*;
#(
    parameter int LINE_STRIDE = LINE_STRIDE_DEF,
    parameter int FRAME_ROWS  = FRAME_ROWS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire crfe_cmd_t                 cmd,
    output crfe_sts_t                      sts,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [COORD_W-1:0] pos_x,
    input  wire logic signed [COORD_W-1:0] pos_y,
    input  wire logic signed [COORD_W-1:0] rect_width,
    input  wire logic signed [COORD_W-1:0] rect_height,
    input  wire logic [COLOR_W-1:0]        fill_color,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    output logic [COLOR_W-1:0]             read_data,
    output logic [COUNT_W-1:0]             pixels_touched
);

    localparam int XW    = $clog2(LINE_STRIDE);
    localparam int YW    = $clog2(FRAME_ROWS);
    localparam int DEPTH = LINE_STRIDE * FRAME_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = XW + YW + 2;
    localparam logic signed [CLIP_W-1:0] LS_C  = CLIP_W'(LINE_STRIDE);
    localparam logic signed [CLIP_W-1:0] FR_C  = CLIP_W'(FRAME_ROWS);
    localparam logic signed [CLIP_W-1:0] ONE_C = CLIP_W'(1);
    localparam logic signed [CLIP_W-1:0] ZERO_C = CLIP_W'(0);

    logic [EDGE_W-1:0]   clip_left_reg;
    logic [EDGE_W-1:0]   clip_top_reg;
    logic [EDGE_W-1:0]   clip_right_reg;
    logic [EDGE_W-1:0]   clip_bottom_reg;
    logic [SCREEN_W-1:0] screen_width_reg;
    logic [COLOR_W-1:0]  mix_threshold_reg;
    logic [COLOR_W-1:0]  mix_color_reg;

    logic [FUNC_W-1:0]         func_reg;
    logic signed [COORD_W-1:0] tx_reg;
    logic signed [COORD_W-1:0] ty_reg;
    logic signed [COORD_W-1:0] w_reg;
    logic signed [COORD_W-1:0] h_reg;
    logic [COLOR_W-1:0]        color_reg;

    logic signed [CLIP_W-1:0] x0_reg;
    logic signed [CLIP_W-1:0] xe_reg;
    logic signed [CLIP_W-1:0] y0_reg;
    logic signed [CLIP_W-1:0] ye_reg;
    logic                     in_range_reg;
    logic                     empty_reg;
    logic [XW-1:0]            wid_m1_reg;
    logic [YW-1:0]            hgt_m1_reg;
    logic [AW-1:0]            row_base_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic [XW-1:0] xcnt_reg;
    logic [YW-1:0] ycnt_reg;
    logic [AW-1:0] line_addr_reg;
    logic [AW-1:0] cur_addr_reg;
    logic          pipe_valid_reg;
    logic [AW-1:0] pipe_addr_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [COLOR_W-1:0] read_data_reg;
    logic [COUNT_W-1:0] touched_reg;

    logic signed [CLIP_W-1:0] tx_e, ty_e, w_e, h_e;
    logic signed [CLIP_W-1:0] cl_e, ct_e, cr1_e, cb1_e, sw_e;
    logic signed [CLIP_W-1:0] x0_c, y0_c, xe_c, ye_c;
    logic signed [CLIP_W-1:0] wid_c, hgt_c, wid_m1_c, hgt_m1_c;
    logic                     is_read;
    logic                     in_range_c;
    logic [XW:0]              wid_n;
    logic [YW:0]              hgt_n;
    logic [PW-1:0]            prod;
    logic [31:0]              prod32;
    logic                     row_last;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COLOR_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [COLOR_W-1:0] ram_rdata;
    logic [COLOR_W-1:0] pix_new;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg     <= CLIP_LEFT_RST;
            clip_top_reg      <= CLIP_TOP_RST;
            clip_right_reg    <= CLIP_RIGHT_RST;
            clip_bottom_reg   <= CLIP_BOTTOM_RST;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            mix_threshold_reg <= MIX_THRESHOLD_RST;
            mix_color_reg     <= MIX_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLIP_LEFT:     clip_left_reg     <= cfg_data[EDGE_W-1:0];
                REG_CLIP_TOP:      clip_top_reg      <= cfg_data[EDGE_W-1:0];
                REG_CLIP_RIGHT:    clip_right_reg    <= cfg_data[EDGE_W-1:0];
                REG_CLIP_BOTTOM:   clip_bottom_reg   <= cfg_data[EDGE_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SCREEN_W-1:0];
                REG_MIX_THRESHOLD: mix_threshold_reg <= cfg_data[COLOR_W-1:0];
                REG_MIX_COLOR:     mix_color_reg     <= cfg_data[COLOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clipping: the rectangle is kept as a start edge and an exclusive end edge.
    assign is_read = (func_reg == FUNC_READ);
    assign tx_e    = CLIP_W'(tx_reg);
    assign ty_e    = CLIP_W'(ty_reg);
    assign w_e     = CLIP_W'(w_reg);
    assign h_e     = CLIP_W'(h_reg);
    assign cl_e    = CLIP_W'(clip_left_reg);
    assign ct_e    = CLIP_W'(clip_top_reg);
    assign cr1_e   = CLIP_W'(clip_right_reg) + ONE_C;
    assign cb1_e   = CLIP_W'(clip_bottom_reg) + ONE_C;
    assign sw_e    = CLIP_W'(screen_width_reg);

    always_comb
    begin
        x0_c = (tx_e < cl_e) ? cl_e : tx_e;
        y0_c = (ty_e < ct_e) ? ct_e : ty_e;
        xe_c = tx_e + w_e;
        if (cr1_e < xe_c)
        begin
            xe_c = cr1_e;
        end
        if ((func_reg != FUNC_OR) && (sw_e < xe_c))
        begin
            xe_c = sw_e;
        end
        if (LS_C < xe_c)
        begin
            xe_c = LS_C;
        end
        ye_c = ty_e + h_e;
        if (cb1_e < ye_c)
        begin
            ye_c = cb1_e;
        end
        if (FR_C < ye_c)
        begin
            ye_c = FR_C;
        end
    end

    assign in_range_c = (tx_e >= ZERO_C) && (tx_e < LS_C) && (ty_e >= ZERO_C) && (ty_e < FR_C);
    assign wid_c      = xe_reg - x0_reg;
    assign hgt_c      = ye_reg - y0_reg;
    assign wid_m1_c   = wid_c - ONE_C;
    assign hgt_m1_c   = hgt_c - ONE_C;
    assign wid_n      = {1'b0, wid_m1_reg} + (XW+1)'(1);
    assign hgt_n      = {1'b0, hgt_m1_reg} + (YW+1)'(1);
    assign prod       = PW'(wid_n) * PW'(hgt_n);
    assign prod32     = 32'(prod);
    assign row_last   = (xcnt_reg == wid_m1_reg);

    assign sts.clear_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign sts.is_read    = is_read;
    assign sts.empty      = empty_reg;
    assign sts.walk_last  = row_last && (ycnt_reg == hgt_m1_reg);

    // Command capture, clipping, sizing and walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            tx_reg    <= pos_x;
            ty_reg    <= pos_y;
            w_reg     <= rect_width;
            h_reg     <= rect_height;
            color_reg <= fill_color;
        end
        if (cmd.clip)
        begin
            x0_reg       <= is_read ? tx_e : x0_c;
            y0_reg       <= is_read ? ty_e : y0_c;
            xe_reg       <= xe_c;
            ye_reg       <= ye_c;
            in_range_reg <= in_range_c;
        end
        if (cmd.size)
        begin
            empty_reg    <= (wid_c <= ZERO_C) || (hgt_c <= ZERO_C);
            wid_m1_reg   <= wid_m1_c[XW-1:0];
            hgt_m1_reg   <= hgt_m1_c[YW-1:0];
            row_base_reg <= AW'(y0_reg[YW-1:0] * LINE_STRIDE);
        end
        if (cmd.count)
        begin
            count_reg     <= empty_reg ? '0
                           : ((prod32 > 32'(COUNT_MAX)) ? COUNT_MAX : prod32[COUNT_W-1:0]);
            xcnt_reg      <= '0;
            ycnt_reg      <= '0;
            line_addr_reg <= AW'(row_base_reg + AW'(x0_reg[XW-1:0]));
            cur_addr_reg  <= AW'(row_base_reg + AW'(x0_reg[XW-1:0]));
        end
        else if (cmd.walk)
        begin
            if (row_last)
            begin
                xcnt_reg      <= '0;
                ycnt_reg      <= ycnt_reg + YW'(1);
                line_addr_reg <= AW'(line_addr_reg + LINE_STRIDE);
                cur_addr_reg  <= AW'(line_addr_reg + LINE_STRIDE);
            end
            else
            begin
                xcnt_reg     <= xcnt_reg + XW'(1);
                cur_addr_reg <= cur_addr_reg + AW'(1);
            end
        end
        pipe_addr_reg <= cur_addr_reg;
        if (cmd.result_load)
        begin
            read_data_reg <= (is_read && in_range_reg) ? ram_rdata : '0;
            touched_reg   <= is_read ? '0 : count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            clr_addr_reg   <= '0;
        end
        else
        begin
            pipe_valid_reg <= cmd.walk;
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Pixel update from the registered read data of the frame store.
    always_comb
    begin
        case (func_reg)
            FUNC_OVERWRITE: pix_new = color_reg;
            FUNC_OR:        pix_new = ram_rdata | color_reg;
            FUNC_MIX:
            begin
                if (ram_rdata == '0)
                begin
                    pix_new = color_reg;
                end
                else if ((ram_rdata > mix_threshold_reg) && (ram_rdata != color_reg))
                begin
                    pix_new = mix_color_reg;
                end
                else
                begin
                    pix_new = ram_rdata;
                end
            end
            default:        pix_new = ram_rdata;
        endcase
    end

    assign ram_we    = cmd.clear_step || pipe_valid_reg;
    assign ram_waddr = cmd.clear_step ? clr_addr_reg : pipe_addr_reg;
    assign ram_wdata = cmd.clear_step ? '0 : pix_new;
    assign ram_re    = cmd.walk || (cmd.read_issue && in_range_reg);
    assign ram_raddr = cmd.read_issue ? AW'(row_base_reg + AW'(x0_reg[XW-1:0])) : cur_addr_reg;

    crfe_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign read_data      = read_data_reg;
    assign pixels_touched = touched_reg;

endmodule

`default_nettype wire

// ===== sv/clipped_rect_fill_engine.sv =====
// ============================================================================
// clipped_rect_fill_engine
// Byte-per-pixel frame store with clipped rectangle fills and pixel reads.
// ============================================================================
// After reset the block clears all LINE_STRIDE * FRAME_ROWS pixels of the
// frame store (786432 at the default size) one pixel per cycle; no
// command beat is accepted during that pass, while configuration writes are
// taken at any time. Commands are then handled one at a time. In a fill the
// frame store has one read and one write port, and each pixel of the clipped
// rectangle is read, updated and written back at one pixel per cycle.
// Results wait in an output register, so the next command is accepted while
// the previous result is still pending.
`default_nettype none

module clipped_rect_fill_engine
    import crfe_pkg::*;
#(
    parameter int LINE_STRIDE = LINE_STRIDE_DEF,
    parameter int FRAME_ROWS  = FRAME_ROWS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pos_x[11:0], pos_y[23:12], rect_width[35:24], rect_height[47:36],
    // fill_color[55:48]
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // func[1:0]
    input  wire logic [FUNC_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // read_data[7:0], pixels_touched[27:8], zero[31:28]
    output logic [M_DATA_W-1:0]        m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    crfe_cmd_t          cmd;
    crfe_sts_t          sts;
    logic [COLOR_W-1:0] read_data;
    logic [COUNT_W-1:0] pixels_touched;

    crfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    crfe_dp #(
        .LINE_STRIDE (LINE_STRIDE),
        .FRAME_ROWS  (FRAME_ROWS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (s_tuser),
        .pos_x          (s_tdata[11:0]),
        .pos_y          (s_tdata[23:12]),
        .rect_width     (s_tdata[35:24]),
        .rect_height    (s_tdata[47:36]),
        .fill_color     (s_tdata[55:48]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .read_data      (read_data),
        .pixels_touched (pixels_touched)
    );

    assign m_tdata = {4'b0000, pixels_touched, read_data};

endmodule

`default_nettype wire
